@@ sv/xbr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xbr_pkg
// Shared types, constants and the interesting-value pool for the bounded
// xoshiro256** random source.
// ----------------------------------------------------------------------------
package xbr_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] DEFAULT_SEED = 64'hDEAD_BEEF_CAFE_BABE;

  // request actions
  localparam logic [1:0] ACT_RAW   = 2'd0;
  localparam logic [1:0] ACT_BELOW = 2'd1;
  localparam logic [1:0] ACT_ONEIN = 2'd2;
  localparam logic [1:0] ACT_POOL  = 2'd3;

  // multiplier operand pairs
  localparam logic [1:0] MSEL_DRAW = 2'd0;
  localparam logic [1:0] MSEL_MIX1 = 2'd1;
  localparam logic [1:0] MSEL_MIX2 = 2'd2;

  // draw bound sources
  localparam logic [1:0] NSEL_BOUND = 2'd0;
  localparam logic [1:0] NSEL_POOL  = 2'd1;
  localparam logic [1:0] NSEL_QUART = 2'd2;
  localparam logic [1:0] NSEL_DELTA = 2'd3;

  // result word sources
  localparam logic [2:0] VSEL_ZERO  = 3'd0;
  localparam logic [2:0] VSEL_RND   = 3'd1;
  localparam logic [2:0] VSEL_HI    = 3'd2;
  localparam logic [2:0] VSEL_POOL  = 3'd3;
  localparam logic [2:0] VSEL_DELTA = 3'd4;

  typedef struct packed {
    logic       in_load;
    logic       sm_add;
    logic       sm_shift;
    logic       gen_step;
    logic       gen_fin;
    logic       mul_start;
    logic [1:0] msel;
    logic       div_start;
    logic       n_load;
    logic [1:0] nsel;
    logic       v_load;
    logic [2:0] vsel;
    logic       out_load;
  } xbr_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic lo_lt_n;
    logic lo_lt_thr;
    logic hi_zero;
    logic bnd_zero;
    logic bnd_le1;
  } xbr_sts_t;

  function automatic logic [63:0] pool_word(input logic [5:0] idx);
    logic [63:0] w;
    case (idx)
      6'd0:  w = 64'd0;
      6'd1:  w = 64'd1;
      6'd2:  w = 64'd2;
      6'd3:  w = 64'd3;
      6'd4:  w = 64'd4;
      6'd5:  w = 64'd7;
      6'd6:  w = 64'd8;
      6'd7:  w = 64'd15;
      6'd8:  w = 64'd16;
      6'd9:  w = 64'd31;
      6'd10: w = 64'd32;
      6'd11: w = 64'd63;
      6'd12: w = 64'd64;
      6'd13: w = 64'd127;
      6'd14: w = 64'd128;
      6'd15: w = 64'd255;
      6'd16: w = 64'd256;
      6'd17: w = 64'd511;
      6'd18: w = 64'd512;
      6'd19: w = 64'd1023;
      6'd20: w = 64'd1024;
      6'd21: w = 64'd4095;
      6'd22: w = 64'd4096;
      6'd23: w = 64'd16383;
      6'd24: w = 64'd16384;
      6'd25: w = 64'd65535;
      6'd26: w = 64'd65536;
      6'd27: w = 64'h0000_0000_7FFF_FFFF;
      6'd28: w = 64'h0000_0000_8000_0000;
      6'd29: w = 64'h0000_0000_FFFF_FFFF;
      6'd30: w = 64'h0000_0001_0000_0000;
      6'd31: w = 64'h7FFF_FFFF_FFFF_FFFF;
      6'd32: w = 64'h8000_0000_0000_0000;
      6'd33: w = 64'hFFFF_FFFF_FFFF_FFFF;
      6'd34: w = 64'hFFFF_FFFF_FFFF_FFFE;
      6'd35: w = 64'hFFFF_FFFF_FFFF_FFFF;
      6'd36: w = 64'hFFFF_FFFF_FFFF_FFFE;
      6'd37: w = 64'hFFFF_FFFF_FFFF_F000;
      6'd38: w = 64'h4000_0000_0000_0000;
      6'd39: w = 64'h0000_0000_DEAD_BEEF;
      6'd40: w = 64'h0000_0000_4141_4141;
      6'd41: w = 64'h0000_0001_0000_0000;
      6'd42: w = 64'hAAAA_AAAA_AAAA_AAAA;
      6'd43: w = 64'h5555_5555_5555_5555;
      default: w = 64'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ sv/xbr_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xbr_dp
// Datapath: generator state, seed mixer, 32x32 multiply-accumulate unit,
// bit-serial remainder unit and result registers.
// ----------------------------------------------------------------------------
module xbr_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [63:0]      cfg_data,
  input  wire logic [63:0]      in_bound,
  input  wire xbr_pkg::xbr_cmd_t cmd,
  output xbr_pkg::xbr_sts_t     sts,
  output logic [63:0]           out_value
);
  import xbr_pkg::*;

  logic [63:0]  s0_r, s1_r, s2_r, s3_r;
  logic [63:0]  sacc_r;
  logic [63:0]  t_r, rnd_r;
  logic [63:0]  bnd_r, n_r;
  logic [63:0]  ma_r, mb_r;
  logic [127:0] prod_r;
  logic [1:0]   mcnt_r;
  logic         mbusy_r;
  logic [63:0]  rem_r, dv_r;
  logic [5:0]   dcnt_r;
  logic         dbusy_r;
  logic [63:0]  val_r, out_value_r;

  logic [63:0]  s1x5, lo, hi;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] term;
  logic [64:0]  dtrial;
  logic [63:0]  delta;
  logic [63:0]  n2, n3;

  assign lo = prod_r[63:0];
  assign hi = prod_r[127:64];
  assign s1x5 = s1_r + {s1_r[61:0], 2'b00};
  assign n2 = s2_r ^ s0_r;
  assign n3 = s3_r ^ s1_r;

  assign a_part = mcnt_r[0] ? ma_r[63:32] : ma_r[31:0];
  assign b_part = mcnt_r[1] ? mb_r[63:32] : mb_r[31:0];
  assign pp = a_part * b_part;
  always_comb begin
    unique case ({1'b0, mcnt_r[0]} + {1'b0, mcnt_r[1]})
      2'd0:    term = {64'd0, pp};
      2'd1:    term = {32'd0, pp, 32'd0};
      default: term = {pp, 64'd0};
    endcase
  end

  assign dtrial = {rem_r, dv_r[63]};
  // hi < 9 here, so the delta fits a small signed value
  assign delta = {{60{1'b0}}, hi[3:0]} - 64'd4;

  // generator state and seed mixer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sacc_r <= DEFAULT_SEED;
    end else if (cfg_we) begin
      sacc_r <= (cfg_data == 64'd0) ? DEFAULT_SEED : cfg_data;
    end else if (cmd.sm_add) begin
      sacc_r <= sacc_r + GOLDEN_GAMMA;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sm_shift) begin
      s0_r <= s1_r;
      s1_r <= s2_r;
      s2_r <= s3_r;
      s3_r <= lo ^ {31'd0, lo[63:31]};
    end else if (cmd.gen_step) begin
      t_r  <= {s1x5[56:0], s1x5[63:57]};
      s0_r <= s0_r ^ n3;
      s1_r <= s1_r ^ n2;
      s2_r <= n2 ^ {s1_r[46:0], 17'd0};
      s3_r <= {n3[18:0], n3[63:19]};
    end
    if (cmd.gen_fin) begin
      rnd_r <= t_r + {t_r[60:0], 3'b000};
    end
  end

  // bound capture and draw bound
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      bnd_r <= in_bound;
    end
    if (cmd.n_load) begin
      unique case (cmd.nsel)
        NSEL_BOUND: n_r <= bnd_r;
        NSEL_POOL:  n_r <= 64'd44;
        NSEL_QUART: n_r <= 64'd4;
        default:    n_r <= 64'd9;
      endcase
    end
  end

  // multiply-accumulate: one 32x32 partial product per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mcnt_r  <= 2'd0;
    end else if (cmd.mul_start) begin
      mbusy_r <= 1'b1;
      mcnt_r  <= 2'd0;
    end else if (mbusy_r) begin
      mcnt_r  <= mcnt_r + 2'd1;
      mbusy_r <= (mcnt_r != 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      prod_r <= 128'd0;
      unique case (cmd.msel)
        MSEL_DRAW: begin
          ma_r <= rnd_r;
          mb_r <= n_r;
        end
        MSEL_MIX1: begin
          ma_r <= sacc_r ^ {30'd0, sacc_r[63:30]};
          mb_r <= MIX_MUL_A;
        end
        default: begin
          ma_r <= lo ^ {27'd0, lo[63:27]};
          mb_r <= MIX_MUL_B;
        end
      endcase
    end else if (mbusy_r) begin
      prod_r <= prod_r + term;
    end
  end

  // restoring remainder of (2^64 - n) by n, one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= 6'd0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= 6'd0;
    end else if (dbusy_r) begin
      dcnt_r  <= dcnt_r + 6'd1;
      dbusy_r <= (dcnt_r != 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= 64'd0;
      dv_r  <= 64'd0 - n_r;
    end else if (dbusy_r) begin
      dv_r <= {dv_r[62:0], 1'b0};
      if (dtrial >= {1'b0, n_r}) begin
        rem_r <= 64'(dtrial - {1'b0, n_r});
      end else begin
        rem_r <= dtrial[63:0];
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.v_load) begin
      unique case (cmd.vsel)
        VSEL_ZERO:  val_r <= 64'd0;
        VSEL_RND:   val_r <= rnd_r;
        VSEL_HI:    val_r <= hi;
        VSEL_POOL:  val_r <= pool_word(hi[5:0]);
        VSEL_DELTA: val_r <= val_r + delta;
        default:    val_r <= 64'd0;
      endcase
    end
    if (cmd.out_load) begin
      out_value_r <= val_r;
    end
  end

  assign out_value = out_value_r;

  always_comb begin
    sts.mul_busy  = mbusy_r;
    sts.div_busy  = dbusy_r;
    sts.lo_lt_n   = (lo < n_r);
    sts.lo_lt_thr = (lo < rem_r);
    sts.hi_zero   = (hi == 64'd0);
    sts.bnd_zero  = (bnd_r == 64'd0);
    sts.bnd_le1   = (bnd_r[63:1] == 63'd0);
  end

endmodule
`default_nettype wire

@@ sv/xbr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xbr_ctrl
// Sequencer: seed expansion, draw loop with rejection, action dispatch and
// output handshake.
// ----------------------------------------------------------------------------
module xbr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_action,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_hit,
  input  wire xbr_pkg::xbr_sts_t sts,
  output xbr_pkg::xbr_cmd_t     cmd
);
  import xbr_pkg::*;

  localparam logic [3:0] S_SM_ADD = 4'd0;
  localparam logic [3:0] S_SM_M1  = 4'd1;
  localparam logic [3:0] S_SM_W1  = 4'd2;
  localparam logic [3:0] S_SM_M2  = 4'd3;
  localparam logic [3:0] S_SM_W2  = 4'd4;
  localparam logic [3:0] S_SM_WR  = 4'd5;
  localparam logic [3:0] S_IDLE   = 4'd6;
  localparam logic [3:0] S_DISP   = 4'd7;
  localparam logic [3:0] S_GEN1   = 4'd8;
  localparam logic [3:0] S_GEN2   = 4'd9;
  localparam logic [3:0] S_MUL    = 4'd10;
  localparam logic [3:0] S_MULW   = 4'd11;
  localparam logic [3:0] S_CHK    = 4'd12;
  localparam logic [3:0] S_DIVW   = 4'd13;
  localparam logic [3:0] S_DRAWN  = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  localparam logic [1:0] PH_POOL  = 2'd0;
  localparam logic [1:0] PH_QUART = 2'd1;
  localparam logic [1:0] PH_DELTA = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] wcnt_r, wcnt_nxt;
  logic [1:0] act_r, act_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       thr_ok_r, thr_ok_nxt;
  logic       hit_r, hit_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_hit_r, out_hit_nxt;

  always_comb begin
    state_nxt     = state_r;
    wcnt_nxt      = wcnt_r;
    act_nxt       = act_r;
    phase_nxt     = phase_r;
    thr_ok_nxt    = thr_ok_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_hit_nxt   = out_hit_r;
    cmd           = '0;
    in_ready      = (state_r == S_IDLE);

    unique case (state_r)
      S_SM_ADD: begin
        cmd.sm_add = 1'b1;
        state_nxt  = S_SM_M1;
      end
      S_SM_M1: begin
        cmd.mul_start = 1'b1;
        cmd.msel      = MSEL_MIX1;
        state_nxt     = S_SM_W1;
      end
      S_SM_W1: begin
        if (!sts.mul_busy) state_nxt = S_SM_M2;
      end
      S_SM_M2: begin
        cmd.mul_start = 1'b1;
        cmd.msel      = MSEL_MIX2;
        state_nxt     = S_SM_W2;
      end
      S_SM_W2: begin
        if (!sts.mul_busy) state_nxt = S_SM_WR;
      end
      S_SM_WR: begin
        cmd.sm_shift = 1'b1;
        wcnt_nxt     = wcnt_r + 2'd1;
        state_nxt    = (wcnt_r == 2'd3) ? S_IDLE : S_SM_ADD;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          act_nxt     = in_action;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        hit_nxt    = 1'b0;
        thr_ok_nxt = 1'b0;
        cmd.v_load = 1'b1;
        cmd.vsel   = VSEL_ZERO;
        state_nxt  = S_GEN1;
        unique case (act_r)
          ACT_RAW: ;
          ACT_BELOW: begin
            cmd.n_load = 1'b1;
            cmd.nsel   = NSEL_BOUND;
            if (sts.bnd_zero) state_nxt = S_FIN;
          end
          ACT_ONEIN: begin
            cmd.n_load = 1'b1;
            cmd.nsel   = NSEL_BOUND;
            if (sts.bnd_le1) begin
              hit_nxt   = 1'b1;
              state_nxt = S_FIN;
            end
          end
          default: begin
            cmd.n_load = 1'b1;
            cmd.nsel   = NSEL_POOL;
            phase_nxt  = PH_POOL;
          end
        endcase
      end
      S_GEN1: begin
        cmd.gen_step = 1'b1;
        state_nxt    = S_GEN2;
      end
      S_GEN2: begin
        cmd.gen_fin = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        if (act_r == ACT_RAW) begin
          cmd.v_load = 1'b1;
          cmd.vsel   = VSEL_RND;
          state_nxt  = S_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.msel      = MSEL_DRAW;
          state_nxt     = S_MULW;
        end
      end
      S_MULW: begin
        if (!sts.mul_busy) state_nxt = S_CHK;
      end
      S_CHK: begin
        // reject only below the threshold, computed once per draw
        if (!sts.lo_lt_n) begin
          state_nxt = S_DRAWN;
        end else if (!thr_ok_r) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVW;
        end else if (sts.lo_lt_thr) begin
          state_nxt = S_GEN1;
        end else begin
          state_nxt = S_DRAWN;
        end
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          thr_ok_nxt = 1'b1;
          state_nxt  = S_CHK;
        end
      end
      S_DRAWN: begin
        state_nxt  = S_FIN;
        thr_ok_nxt = 1'b0;
        unique case (act_r)
          ACT_ONEIN: hit_nxt = sts.hi_zero;
          ACT_POOL: begin
            unique case (phase_r)
              PH_POOL: begin
                cmd.v_load = 1'b1;
                cmd.vsel   = VSEL_POOL;
                cmd.n_load = 1'b1;
                cmd.nsel   = NSEL_QUART;
                phase_nxt  = PH_QUART;
                state_nxt  = S_GEN1;
              end
              PH_QUART: begin
                if (sts.hi_zero) begin
                  cmd.n_load = 1'b1;
                  cmd.nsel   = NSEL_DELTA;
                  phase_nxt  = PH_DELTA;
                  state_nxt  = S_GEN1;
                end
              end
              default: begin
                cmd.v_load = 1'b1;
                cmd.vsel   = VSEL_DELTA;
              end
            endcase
          end
          default: begin
            cmd.v_load = 1'b1;
            cmd.vsel   = VSEL_HI;
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      state_nxt = S_SM_ADD;
      wcnt_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SM_ADD;
      wcnt_r      <= 2'd0;
      act_r       <= ACT_RAW;
      phase_r     <= PH_POOL;
      thr_ok_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wcnt_r      <= wcnt_nxt;
      act_r       <= act_nxt;
      phase_r     <= phase_nxt;
      thr_ok_r    <= thr_ok_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      out_hit_r   <= out_hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule
`default_nettype wire

@@ sv/xoshiro256ss_bounded_random.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xoshiro256ss_bounded_random
// xoshiro256** source with raw words, unbiased bounded draws, one-in-n flags
// and picks from a pool of interesting values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries in_action and in_bound; the
//   result channel (out_valid/out_ready) carries out_value and out_hit.
//   cfg_we with cfg_data reseeds; write only while the block is idle.
//   One request is in flight at a time. Each generator word takes a step
//   state and a finish state; each bounded draw adds the 32x32
//   multiply-accumulate and the check, plus the bit-serial threshold
//   remainder when the low product word falls below the bound. A rejected
//   draw retries with a new generator word; a zero bound skips the draw.
//   An interesting value takes two or three draws. Reset and every seed
//   write run the SplitMix64 expansion with in_ready low. A finished result
//   sits in the output register; the next transfer is accepted while it
//   waits, but that item holds in its final state until the receiver takes
//   the earlier result.
// ----------------------------------------------------------------------------
module xoshiro256ss_bounded_random (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [63:0] in_bound,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_value,
  output logic             out_hit
);
  import xbr_pkg::*;

  xbr_cmd_t cmd;
  xbr_sts_t sts;

  // sequencer: expansion, draw loop, dispatch, output handshake
  xbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hit   (out_hit),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: generator state, multiplier, remainder unit, result word
  xbr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_bound  (in_bound),
    .cmd       (cmd),
    .sts       (sts),
    .out_value (out_value)
  );

  // one request at a time: after a transfer in, no second one next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // a reseed always blocks new requests while the state is rebuilt
  a_reseed_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("request accepted during seed expansion");

  // the shared units are never busy together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.mul_busy && sts.div_busy))
    else $error("multiplier and remainder unit both busy");

  // a hit result carries a zero word
  a_hit_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_value == 64'd0))
    else $error("hit result with nonzero value");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded xoshiro256** source: a directed table
// of requests on the reset seed, then random traffic under random stalls on
// both sides, every result compared with a behavioral copy of the generator.
// ----------------------------------------------------------------------------
module testbench;
  import xbr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_RAW;
  logic [63:0] in_bound = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_value;
  logic        out_hit;

  xoshiro256ss_bounded_random i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_bound(in_bound), .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_hit(out_hit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [63:0] value;
    logic        hit;
  } draw_result_t;

  // Generator state of the behavioral copy.
  logic [63:0]  gen_state [4];
  draw_result_t pending_draws [$];
  int           mismatches = 0;
  bit           hold_receiver = 1'b0;
  int           long_hold = 0;

  function automatic logic [63:0] rotl(input logic [63:0] v, input int k);
    return (v << k) | (v >> (64 - k));
  endfunction

  task automatic reseed_model(input logic [63:0] sd);
    logic [63:0] acc;
    logic [63:0] z;
    acc = (sd == 64'd0) ? DEFAULT_SEED : sd;
    for (int i = 0; i < 4; i++) begin
      acc = acc + GOLDEN_GAMMA;
      z = acc;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      gen_state[i] = z ^ (z >> 31);
    end
  endtask

  task automatic step_generator(output logic [63:0] w);
    logic [63:0] sh;
    w = rotl(gen_state[1] * 64'd5, 7) * 64'd9;
    sh = gen_state[1] << 17;
    gen_state[2] ^= gen_state[0];
    gen_state[3] ^= gen_state[1];
    gen_state[1] ^= gen_state[2];
    gen_state[0] ^= gen_state[3];
    gen_state[2] ^= sh;
    gen_state[3] = rotl(gen_state[3], 45);
  endtask

  // Lemire multiply-and-reject draw in [0, n).
  task automatic draw_under(input logic [63:0] n, output logic [63:0] r);
    logic [63:0]  w;
    logic [127:0] p;
    logic [63:0]  thr;
    if (n == 64'd0) begin
      r = 64'd0;
      return;
    end
    step_generator(w);
    p = {64'd0, w} * {64'd0, n};
    if (p[63:0] < n) begin
      thr = (64'd0 - n) % n;
      while (p[63:0] < thr) begin
        step_generator(w);
        p = {64'd0, w} * {64'd0, n};
      end
    end
    r = p[127:64];
  endtask

  task automatic predict_draw(input logic [1:0] act, input logic [63:0] bnd);
    draw_result_t e;
    logic [63:0]  t;
    e.value = 64'd0;
    e.hit = 1'b0;
    case (act)
      ACT_RAW: begin
        step_generator(e.value);
      end
      ACT_BELOW: begin
        draw_under(bnd, e.value);
      end
      ACT_ONEIN: begin
        if (bnd <= 64'd1) begin
          e.hit = 1'b1;
        end else begin
          draw_under(bnd, t);
          e.hit = (t == 64'd0);
        end
      end
      default: begin
        draw_under(64'd44, t);
        e.value = pool_word(t[5:0]);
        draw_under(64'd4, t);
        if (t == 64'd0) begin
          draw_under(64'd9, t);
          e.value = e.value + t - 64'd4;
        end
      end
    endcase
    pending_draws.push_back(e);
  endtask

  // Check every transfer on the result side against the oldest prediction.
  always @(posedge clk) begin
    draw_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h hit=%b", out_value, out_hit);
      end else begin
        e = pending_draws.pop_front();
        if (e.value !== out_value || e.hit !== out_hit) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected value=%h hit=%b, got value=%h hit=%b",
                     e.value, e.hit, out_value, out_hit);
          end
        end
      end
    end
  end

  // Receiver: random stall per result, plus one long hold-off on request.
  initial begin
    int gap;
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        hold_receiver = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      // hold ready until a transfer happens
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one request and wait for its transfer; valid stays up when the
  // next request follows with no gap.
  task automatic send_request(input logic [1:0] act, input logic [63:0] bnd,
                              input bit stall);
    int gap;
    gap = stall ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_bound  <= bnd;
    do @(posedge clk); while (!in_ready);
    predict_draw(act, bnd);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] sd);
    cfg_we   <= 1'b1;
    cfg_data <= sd;
    @(posedge clk);
    cfg_we <= 1'b0;
    reseed_model(sd);
  endtask

  typedef struct {
    logic [1:0]  act;
    logic [63:0] bnd;
    bit          known;     // result typed in below
    logic [63:0] value;
    logic        hit;
  } request_row_t;

  // Directed rows; known results cover the no-draw special cases only.
  request_row_t directed_rows [] = '{
    '{ACT_BELOW, 64'd0, 1'b1, 64'd0, 1'b0},
    '{ACT_ONEIN, 64'd0, 1'b1, 64'd0, 1'b1},
    '{ACT_ONEIN, 64'd1, 1'b1, 64'd0, 1'b1},
    '{ACT_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
    '{ACT_RAW, 64'd0, 1'b0, 64'd0, 1'b0},
    '{ACT_BELOW, 64'd1, 1'b0, 64'd0, 1'b0},
    '{ACT_BELOW, 64'd2, 1'b0, 64'd0, 1'b0},
    '{ACT_BELOW, 64'd3, 1'b0, 64'd0, 1'b0},
    '{ACT_BELOW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
    '{ACT_BELOW, 64'h8000_0000_0000_0001, 1'b0, 64'd0, 1'b0},
    '{ACT_BELOW, 64'hC000_0000_0000_0000, 1'b0, 64'd0, 1'b0},
    '{ACT_ONEIN, 64'd2, 1'b0, 64'd0, 1'b0},
    '{ACT_ONEIN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
    '{ACT_POOL, 64'd0, 1'b0, 64'd0, 1'b0},
    '{ACT_POOL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
    '{ACT_POOL, 64'h5555_5555_5555_5555, 1'b0, 64'd0, 1'b0},
    '{ACT_POOL, 64'd7, 1'b0, 64'd0, 1'b0}
  };

  function automatic logic [63:0] random_bound();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 3));
      1: return 64'($urandom_range(0, 100));
      2: return {$urandom, $urandom};
      3: return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 7));
      4: return ~64'($urandom_range(0, 7));
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  initial begin
    draw_result_t e;
    logic [63:0]  seeds [4];
    reseed_model(64'd0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part against the reset seed
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].act, directed_rows[i].bnd, 1'b1);
      if (directed_rows[i].known) begin
        e = pending_draws[$];
        if (e.value !== directed_rows[i].value || e.hit !== directed_rows[i].hit) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("table row %0d: expected value=%h hit=%b, predicted value=%h hit=%b",
                     i, directed_rows[i].value, directed_rows[i].hit, e.value, e.hit);
          end
        end
      end
    end
    wait_drained();

    // random phases over several seeds, extremes included
    seeds[0] = 64'd0;
    seeds[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    seeds[2] = {$urandom, $urandom};
    seeds[3] = 64'd1;
    for (int ph = 0; ph < 4; ph++) begin
      write_seed(seeds[ph]);
      // long receiver hold-off in the second phase to back up the input
      if (ph == 1) begin
        long_hold = 300;
        hold_receiver = 1'b1;
      end
      for (int k = 0; k < 170; k++) begin
        send_request(2'($urandom_range(0, 3)), random_bound(), $urandom_range(0, 4) != 0);
        // sender pause until every result is back
        if (ph == 2 && k == 80) begin
          in_valid <= 1'b0;
          while (pending_draws.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
